/* hw/rtl/eta_pkg.sv */
// Shared types, constants and the spring ROM for the eased tween animator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package eta_pkg;

  localparam int TIME_BITS            = 24;
  localparam int FRACTION_BITS        = 16;
  localparam int SPRING_TABLE_ENTRIES = 1024;

  localparam int VALUE_W = 32;
  localparam int X_W     = FRACTION_BITS + 1;        // progress, 1 - p, 2(1 - p)
  localparam int E_W     = FRACTION_BITS + 3;        // signed eased progress
  localparam int A_W     = 34;                       // multiplier operand A
  localparam int B_W     = E_W;                      // multiplier operand B
  localparam int P_W     = A_W + B_W;
  localparam int IDX_W   = $clog2(SPRING_TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(FRACTION_BITS);
  localparam int QB      = 30;

  localparam logic signed [A_W-1:0] C1_Q30 = A_W'(64'sd1827057613);
  localparam logic signed [A_W-1:0] C3_Q30 = A_W'(64'sd1827057613 + (64'sd1 <<< QB));
  localparam longint Z_Q30 = 64'sd837518623;

  typedef enum logic [1:0] {
    ACT_ADVANCE  = 2'd0,
    ACT_RETARGET = 2'd1,
    ACT_SNAP     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CRV_LINEAR   = 3'd0,
    CRV_OUT_CUB  = 3'd1,
    CRV_INOUT    = 3'd2,
    CRV_OUT_BACK = 3'd3,
    CRV_SPRING   = 3'd4
  } curve_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_DIV, OP_PREP, OP_SQ, OP_CUBE, OP_C2, OP_C3,
    OP_ROM, OP_EASE, OP_LERP, OP_FIN, OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV, S_PREP, S_SQ, S_CUBE, S_C2, S_C3,
    S_ROM, S_EASE, S_LERP, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic       calc;      // advance needs the curve evaluated
    logic       div_last;  // final quotient bit this cycle
    logic [2:0] curve;
  } status_t;

  typedef logic signed [E_W-1:0] spring_rom_t [SPRING_TABLE_ENTRIES];

  // Round a right shift half away from zero.
  function automatic longint rsr(longint x, int n);
    longint m;
    longint half;
    m    = (x < 0) ? -x : x;
    half = (n != 0) ? (64'sd1 <<< (n - 1)) : 64'sd0;
    m    = (m + half) >>> n;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rsr(a * b, QB);
  endfunction

  // Quotient truncated toward zero, by shift and subtract.
  function automatic longint div_trunc(longint num, longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned rem;
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt(longint v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned bt;
    v  = v_in;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(r);
  endfunction

  // Damped spring response, built at elaboration in Q30 and stored in Q.F.
  function automatic spring_rom_t build_spring_rom();
    spring_rom_t tab;
    longint one, s1, sq, aq, bq, kq, x, th, th2;
    longint r, te, cs, tc, sn, ts, rc, rs, c, s, e, nc, ns;
    one = 64'sd1 <<< QB;
    s1  = one - qmul(Z_Q30, Z_Q30);
    sq  = isqrt(s1 <<< QB);
    aq  = 12 * Z_Q30;
    bq  = 12 * sq;
    kq  = div_trunc(Z_Q30 <<< QB, sq);
    x   = aq / SPRING_TABLE_ENTRIES;
    th  = bq / SPRING_TABLE_ENTRIES;
    th2 = qmul(th, th);
    r = one; te = one; cs = one; tc = one; sn = th; ts = th;
    for (int k = 1; k <= 10; k++) begin
      te = div_trunc(-qmul(te, x), k);
      r  = r + te;
      tc = div_trunc(-qmul(tc, th2), (2 * k - 1) * (2 * k));
      cs = cs + tc;
      ts = div_trunc(-qmul(ts, th2), (2 * k) * (2 * k + 1));
      sn = sn + ts;
    end
    rc = qmul(r, cs);
    rs = qmul(r, sn);
    c  = one;
    s  = 0;
    for (int n = 0; n < SPRING_TABLE_ENTRIES; n++) begin
      e  = one - (c + qmul(kq, s));
      nc = qmul(rc, c) - qmul(rs, s);
      ns = qmul(rs, c) + qmul(rc, s);
      tab[n] = E_W'(rsr(e, QB - FRACTION_BITS));
      c = nc;
      s = ns;
    end
    return tab;
  endfunction

  localparam spring_rom_t SPRING_ROM = build_spring_rom();

endpackage

/* hw/rtl/eta_in_if.sv */
// Input channel of the eased tween animator: valid/ready plus one item.
// Depends on eta_pkg for field widths.
`timescale 1ns / 1ps

interface eta_in_if import eta_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [TIME_BITS-1:0]        dt_us;
  logic signed [VALUE_W-1:0]   target_value;
  logic [TIME_BITS-1:0]        duration_us;
  logic [2:0]                  ease_select;

  modport source (output valid, action, dt_us, target_value, duration_us, ease_select,
                  input ready);
  modport sink (input valid, action, dt_us, target_value, duration_us, ease_select,
                output ready);
endinterface

/* hw/rtl/eta_out_if.sv */
// Result channel of the eased tween animator: valid/ready plus one item.
// Depends on eta_pkg for field widths.
`timescale 1ns / 1ps

interface eta_out_if import eta_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] current_out;
  logic                      moving;

  modport source (output valid, current_out, moving, input ready);
  modport sink (input valid, current_out, moving, output ready);
endinterface

/* hw/rtl/eta_ctrl.sv */
// Sequencer of the eased tween animator: steps the datapath through one item.
// Depends on eta_pkg.
`timescale 1ns / 1ps

module eta_ctrl import eta_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = st.calc ? S_DIV : S_OUT;
      S_DIV:   if (st.div_last) state_nxt = S_PREP;
      S_PREP: begin
        priority case (st.curve)
          CRV_OUT_CUB, CRV_INOUT, CRV_OUT_BACK: state_nxt = S_SQ;
          CRV_SPRING:                           state_nxt = S_ROM;
          default:                              state_nxt = S_EASE;
        endcase
      end
      S_SQ:    state_nxt = S_CUBE;
      S_CUBE:  state_nxt = (st.curve == CRV_OUT_BACK) ? S_C2 : S_EASE;
      S_C2:    state_nxt = S_C3;
      S_C3:    state_nxt = S_EASE;
      S_ROM:   state_nxt = S_EASE;
      S_EASE:  state_nxt = S_LERP;
      S_LERP:  state_nxt = S_FIN;
      S_FIN:   state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op        = OP_IDLE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_DIV:  cmd.op = OP_DIV;
      S_PREP: cmd.op = OP_PREP;
      S_SQ:   cmd.op = OP_SQ;
      S_CUBE: cmd.op = OP_CUBE;
      S_C2:   cmd.op = OP_C2;
      S_C3:   cmd.op = OP_C3;
      S_ROM:  cmd.op = OP_ROM;
      S_EASE: cmd.op = OP_EASE;
      S_LERP: cmd.op = OP_LERP;
      S_FIN:  cmd.op = OP_FIN;
      S_OUT: begin
        if (slot_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/eta_dp.sv */
// Datapath of the eased tween animator: state, serial divider, shared
// multiplier, easing and interpolation. Depends on eta_pkg.
`timescale 1ns / 1ps

module eta_dp import eta_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   st,
  input  logic [1:0]                action,
  input  logic [TIME_BITS-1:0]      dt_us,
  input  logic signed [VALUE_W-1:0] target_value,
  input  logic [TIME_BITS-1:0]      duration_us,
  input  logic [2:0]                ease_select,
  output logic signed [VALUE_W-1:0] current_out,
  output logic                      moving
);

  localparam logic [X_W-1:0]  ONE_X = X_W'(1) << FRACTION_BITS;
  localparam logic signed [E_W-1:0] ONE_E = E_W'(1) <<< FRACTION_BITS;
  localparam logic signed [P_W-1:0] HALF_F = P_W'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [P_W-1:0] HALF_Q = P_W'(1) <<< (QB - 1);

  // animation state
  logic signed [VALUE_W-1:0] start_r, end_r, present_r;
  logic [TIME_BITS-1:0]      elapsed_r, total_r;
  logic [2:0]                curve_r;
  logic                      running_r, calc_r;
  // working registers
  logic [TIME_BITS:0]        rem_r;
  logic [FRACTION_BITS-1:0]  q_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [X_W-1:0]            x_r, sq_r, cube_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [E_W-1:0]     t2_r, rom_r, ease_r;
  logic signed [P_W-1:0]     prod_r;
  logic signed [VALUE_W-1:0] out_cur_r;
  logic                      out_mov_r;

  // half-up rounding of a nonnegative Q.F product
  function automatic logic [X_W-1:0] fround(logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] t;
    t = (v + HALF_F) >>> FRACTION_BITS;
    return t[X_W-1:0];
  endfunction

  function automatic logic signed [E_W-1:0] qround(logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] t;
    t = (v + HALF_Q) >>> QB;
    return t[E_W-1:0];
  endfunction

  // time accumulate with saturation
  logic [TIME_BITS:0]   el_sum;
  logic [TIME_BITS-1:0] el_sat;
  assign el_sum = {1'b0, elapsed_r} + {1'b0, dt_us};
  assign el_sat = el_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : el_sum[TIME_BITS-1:0];

  // restoring divide step
  logic [TIME_BITS+1:0] rem2;
  logic                 rem_ge;
  assign rem2   = {rem_r, 1'b0};
  assign rem_ge = rem2 >= {2'b00, total_r};

  // progress forms
  logic [X_W-1:0] p_x, m_x, m2_x;
  logic           p_low;
  logic [IDX_W+FRACTION_BITS-1:0] idx_full;
  assign p_x      = {1'b0, q_r};
  assign m_x      = ONE_X - p_x;
  assign m2_x     = {m_x[X_W-2:0], 1'b0};
  assign p_low    = !q_r[FRACTION_BITS-1];
  assign idx_full = (IDX_W+FRACTION_BITS)'(q_r) * (IDX_W+FRACTION_BITS)'(SPRING_TABLE_ENTRIES);

  // shared multiplier
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] mul_p;
  logic [X_W-1:0]        sq_now, cube_now;
  assign sq_now   = fround(prod_r);
  assign cube_now = fround(prod_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ:   begin mul_a = A_W'(x_r);    mul_b = B_W'(x_r); end
      OP_CUBE: begin mul_a = A_W'(sq_now); mul_b = B_W'(x_r); end
      OP_C2:   begin mul_a = C1_Q30;       mul_b = B_W'(sq_r); end
      OP_C3:   begin mul_a = C3_Q30;       mul_b = B_W'(cube_r); end
      OP_LERP: begin
        mul_a = A_W'(end_r) - A_W'(start_r);
        mul_b = ease_r;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // easing result
  logic signed [E_W-1:0] ease_val;
  always_comb begin
    priority case (curve_r)
      CRV_OUT_CUB:  ease_val = ONE_E - E_W'(cube_now);
      CRV_INOUT:    ease_val = p_low ? (E_W'(cube_now) <<< 2)
                                     : (ONE_E - E_W'(cube_now >> 1));
      CRV_OUT_BACK: ease_val = ONE_E + t2_r - qround(prod_r);
      CRV_SPRING:   ease_val = rom_r;
      default:      ease_val = E_W'(p_x);
    endcase
  end

  // interpolation rounding (half away from zero) and saturation
  logic                  neg;
  logic signed [P_W-1:0] mag, rnd_mag;
  logic signed [A_W-1:0] delta, sum;
  logic signed [VALUE_W-1:0] sat_val;
  always_comb begin
    neg     = prod_r[P_W-1];
    mag     = neg ? -prod_r : prod_r;
    rnd_mag = (mag + HALF_F) >>> FRACTION_BITS;
    delta   = neg ? -A_W'(rnd_mag) : A_W'(rnd_mag);
    sum     = A_W'(start_r) + delta;
    if (sum > A_W'(32'sh7fffffff))       sat_val = 32'sh7fffffff;
    else if (sum < -A_W'(64'sh80000000)) sat_val = 32'sh80000000;
    else                                 sat_val = sum[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      end_r     <= '0;
      present_r <= '0;
      elapsed_r <= '0;
      total_r   <= '0;
      curve_r   <= CRV_LINEAR;
      running_r <= 1'b0;
      calc_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          unique case (action)
            ACT_ADVANCE: begin
              if (running_r) begin
                elapsed_r <= el_sat;
                if (total_r == '0 || el_sat >= total_r) begin
                  present_r <= end_r;
                  running_r <= 1'b0;
                  calc_r    <= 1'b0;
                end else begin
                  calc_r <= 1'b1;
                end
              end else begin
                calc_r <= 1'b0;
              end
              rem_r <= {1'b0, el_sat};
              q_r   <= '0;
              cnt_r <= '0;
            end
            ACT_RETARGET: begin
              calc_r <= 1'b0;
              if (duration_us != '0) begin
                start_r   <= present_r;
                end_r     <= target_value;
                elapsed_r <= '0;
                total_r   <= duration_us;
                curve_r   <= ease_select;
                running_r <= 1'b1;
              end else begin
                start_r   <= target_value;
                end_r     <= target_value;
                present_r <= target_value;
                running_r <= 1'b0;
              end
            end
            ACT_SNAP: begin
              calc_r    <= 1'b0;
              start_r   <= target_value;
              end_r     <= target_value;
              present_r <= target_value;
              elapsed_r <= '0;
              total_r   <= '0;
              running_r <= 1'b0;
            end
            default: calc_r <= 1'b0;
          endcase
        end
        OP_DIV: begin
          rem_r <= rem_ge ? (TIME_BITS+1)'(rem2 - {2'b00, total_r})
                          : rem2[TIME_BITS:0];
          q_r   <= {q_r[FRACTION_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + 1'b1;
        end
        OP_PREP: begin
          x_r   <= (curve_r == CRV_INOUT) ? (p_low ? p_x : m2_x) : m_x;
          idx_r <= idx_full[IDX_W+FRACTION_BITS-1:FRACTION_BITS];
        end
        OP_SQ:   prod_r <= mul_p;
        OP_CUBE: begin
          sq_r   <= sq_now;
          prod_r <= mul_p;
        end
        OP_C2: begin
          cube_r <= cube_now;
          prod_r <= mul_p;
        end
        OP_C3: begin
          t2_r   <= qround(prod_r);
          prod_r <= mul_p;
        end
        OP_ROM:  rom_r  <= SPRING_ROM[idx_r];
        OP_EASE: ease_r <= ease_val;
        OP_LERP: prod_r <= mul_p;
        OP_FIN:  present_r <= sat_val;
        OP_OUT: begin
          out_cur_r <= present_r;
          out_mov_r <= running_r;
        end
        default: calc_r <= calc_r;
      endcase
    end
  end

  assign st.calc     = calc_r;
  assign st.div_last = (cnt_r == CNT_W'(FRACTION_BITS - 1));
  assign st.curve    = curve_r;
  assign current_out = out_cur_r;
  assign moving      = out_mov_r;

endmodule

/* hw/rtl/eased_tween_animator.sv */
// Top level of the eased tween animator: sequencer plus datapath.
// Depends on eta_pkg, eta_in_if, eta_out_if, eta_ctrl and eta_dp.
`timescale 1ns / 1ps

// One animated signed Q16.16 value. Items are taken one at a time; each gives
// exactly one result. Snap, retarget and idle-advance items go from acceptance
// through a check state straight to the result. An advance that evaluates the
// curve runs the serial progress divider, then the curve steps: none for linear,
// a registered ROM read for spring, square and cube on the one shared multiplier
// for the cubic curves, with the coefficient products added for out-back. A new
// item is taken once the result is in the output register; it waits there until the sink takes it.

module eased_tween_animator import eta_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  eta_in_if.sink    in_ch,
  eta_out_if.source out_ch
);

  cmd_t    cmd;
  status_t st;

  eta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  eta_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .action       (in_ch.action),
    .dt_us        (in_ch.dt_us),
    .target_value (in_ch.target_value),
    .duration_us  (in_ch.duration_us),
    .ease_select  (in_ch.ease_select),
    .current_out  (out_ch.current_out),
    .moving       (out_ch.moving)
  );

  // busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accepting an item");

  // a result only appears at the end of item processing
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised while idle");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

/* tb/tb_eased_tween_animator.sv */
// Self-checking testbench for the eased tween animator: directed table, then random items.
// Depends on eta_pkg, eta_in_if, eta_out_if and the eased_tween_animator RTL.
`timescale 1ns / 1ps

module tb_eased_tween_animator import eta_pkg::*; ();

  localparam longint FONE     = 64'sd1 <<< FRACTION_BITS;
  localparam longint TIME_MAX = (64'sd1 <<< TIME_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eta_in_if  in_ch ();
  eta_out_if out_ch ();

  eased_tween_animator dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  typedef struct {
    action_t          action;
    logic [23:0]      dt_us;
    logic signed [31:0] target_value;
    logic [23:0]      duration_us;
    logic [2:0]       ease_select;
  } tween_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic               moving;
  } tween_result_t;

  // Directed row: item plus an optional typed-in expectation.
  typedef struct {
    tween_item_t        item;
    bit                 fixed;
    logic signed [31:0] value;
    logic               moving;
  } tween_row_t;

  // Predictor state and ROM copy
  longint          mdl_start, mdl_end, mdl_present;
  longint          mdl_elapsed, mdl_total;
  logic [2:0]      mdl_curve;
  bit              mdl_running;
  longint          spring_tab [SPRING_TABLE_ENTRIES];

  tween_result_t   pending_results [$];
  int              error_count = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  bit              hold_off = 1'b0;

  // Rounded shift, half away from zero
  function automatic longint shr_round(longint x, int n);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + ((n != 0) ? (64'sd1 <<< (n - 1)) : 0)) >>> n;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return shr_round(a * b, 30);
  endfunction

  function automatic longint frac_mul(longint a, longint b);
    return (a * b + (FONE >>> 1)) >>> FRACTION_BITS;
  endfunction

  function automatic longint frac_cube(longint x);
    return frac_mul(frac_mul(x, x), x);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r  = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return longint'(r);
  endfunction

  // Damped spring step response in Q30, rounded half away from zero to Q.F
  task automatic fill_spring_table();
    longint one, zq, s1, sq, kq, x, th, th2;
    longint r, te, cs, tc, sn, ts, rc, rs, c, s, e, nc, ns;
    one = 64'sd1 <<< 30;
    zq  = 64'sd837518623;
    s1  = one - q30_mul(zq, zq);
    sq  = int_sqrt(s1 <<< 30);
    kq  = (zq <<< 30) / sq;
    x   = (12 * zq) / SPRING_TABLE_ENTRIES;
    th  = (12 * sq) / SPRING_TABLE_ENTRIES;
    th2 = q30_mul(th, th);
    r = one; te = one; cs = one; tc = one; sn = th; ts = th;
    for (int k = 1; k <= 10; k++) begin
      te = -q30_mul(te, x) / k;
      r  = r + te;
      tc = -q30_mul(tc, th2) / ((2 * k - 1) * (2 * k));
      cs = cs + tc;
      ts = -q30_mul(ts, th2) / ((2 * k) * (2 * k + 1));
      sn = sn + ts;
    end
    rc = q30_mul(r, cs);
    rs = q30_mul(r, sn);
    c = one;
    s = 0;
    for (int n = 0; n < SPRING_TABLE_ENTRIES; n++) begin
      e  = one - (c + q30_mul(kq, s));
      nc = q30_mul(rc, c) - q30_mul(rs, s);
      ns = q30_mul(rs, c) + q30_mul(rc, s);
      spring_tab[n] = shr_round(e, 30 - FRACTION_BITS);
      c = nc;
      s = ns;
    end
  endtask

  function automatic longint eased_progress(logic [2:0] sel, longint p);
    longint m, m2, m3, idx;
    m = FONE - p;
    case (sel)
      CRV_OUT_CUB: return FONE - frac_cube(m);
      CRV_INOUT: begin
        if (p < (FONE >>> 1)) return frac_cube(p) <<< 2;
        return FONE - (frac_cube(2 * m) >>> 1);
      end
      CRV_OUT_BACK: begin
        m2 = frac_mul(m, m);
        m3 = frac_mul(m2, m);
        return FONE + shr_round(64'sd1827057613 * m2, 30)
               - shr_round((64'sd1827057613 + (64'sd1 <<< 30)) * m3, 30);
      end
      CRV_SPRING: begin
        idx = (p * SPRING_TABLE_ENTRIES) >>> FRACTION_BITS;
        if (idx >= SPRING_TABLE_ENTRIES) idx = SPRING_TABLE_ENTRIES - 1;
        return spring_tab[idx];
      end
      default: return p;
    endcase
  endfunction

  // Apply one item to the predicted animator state and return its result
  function automatic tween_result_t predict_tween(tween_item_t it);
    tween_result_t res;
    longint p, v;
    case (it.action)
      ACT_ADVANCE: begin
        if (mdl_running) begin
          mdl_elapsed = mdl_elapsed + it.dt_us;
          if (mdl_elapsed > TIME_MAX) mdl_elapsed = TIME_MAX;
          if (mdl_total == 0 || mdl_elapsed >= mdl_total) begin
            mdl_present = mdl_end;
            mdl_running = 1'b0;
          end else begin
            p = (mdl_elapsed <<< FRACTION_BITS) / mdl_total;
            v = mdl_start + shr_round((mdl_end - mdl_start) * eased_progress(mdl_curve, p),
                                      FRACTION_BITS);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            mdl_present = v;
          end
        end
      end
      ACT_RETARGET: begin
        if (it.duration_us != 0) begin
          mdl_start   = mdl_present;
          mdl_end     = it.target_value;
          mdl_elapsed = 0;
          mdl_total   = it.duration_us;
          mdl_curve   = it.ease_select;
          mdl_running = 1'b1;
        end else begin
          mdl_start = it.target_value; mdl_end = it.target_value;
          mdl_present = it.target_value;
          mdl_running = 1'b0;
        end
      end
      ACT_SNAP: begin
        mdl_start = it.target_value; mdl_end = it.target_value;
        mdl_present = it.target_value;
        mdl_elapsed = 0;
        mdl_total   = 0;
        mdl_running = 1'b0;
      end
      default: ;
    endcase
    res.value  = mdl_present[31:0];
    res.moving = mdl_running;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Drive one item and wait for acceptance; valid stays up for a following item
  task automatic send_item(tween_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.dt_us        <= it.dt_us;
    in_ch.target_value <= it.target_value;
    in_ch.duration_us  <= it.duration_us;
    in_ch.ease_select  <= it.ease_select;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sender goes quiet after its last item
  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // Predict, queue and send
  task automatic apply_item(tween_item_t it);
    pending_results.push_back(predict_tween(it));
    send_item(it);
  endtask

  function automatic tween_item_t make_item(action_t a, int dt, int tv, int dur, int es);
    tween_item_t it;
    it.action = a; it.dt_us = 24'(dt); it.target_value = tv;
    it.duration_us = 24'(dur); it.ease_select = 3'(es);
    return it;
  endfunction

  // Random item: mostly advance, otherwise retarget, snap or none
  function automatic tween_item_t random_item();
    tween_item_t it;
    int r;
    r = $urandom_range(99);
    it.target_value = $urandom();
    it.ease_select  = 3'($urandom_range(7));
    it.dt_us        = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(5000));
    it.duration_us  = ($urandom_range(3) == 0) ? 24'($urandom())
                                               : 24'($urandom_range(40000));
    if ($urandom_range(9) == 0) it.duration_us = 0;
    if ($urandom_range(1) == 0) it.target_value = $signed(it.target_value) >>> 8;
    if (r < 60)      it.action = ACT_ADVANCE;
    else if (r < 85) it.action = ACT_RETARGET;
    else if (r < 95) it.action = ACT_SNAP;
    else             it.action = ACT_NONE;
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    tween_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.current_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.current_out !== want.value)
          report_mismatch("current_out", out_ch.current_out, want.value);
        if (out_ch.moving !== want.moving)
          report_mismatch("moving", out_ch.moving, want.moving);
      end
    end
  end

  // Receiver: random stall or a long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  initial begin
    tween_row_t    rows [$];
    tween_row_t    row;
    tween_result_t want;
    int            pct_send [4] = '{0, 78, 0, 12};
    int            pct_recv [4] = '{0, 0, 78, 12};

    in_ch.valid = 1'b0; in_ch.action = ACT_ADVANCE; in_ch.dt_us = '0;
    in_ch.target_value = '0; in_ch.duration_us = '0; in_ch.ease_select = '0;
    fill_spring_table();
    mdl_start = 0; mdl_end = 0; mdl_present = 0; mdl_elapsed = 0; mdl_total = 0;
    mdl_curve = CRV_LINEAR; mdl_running = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; fixed rows carry their expectation
    rows.push_back('{make_item(ACT_ADVANCE, 100, 0, 0, 0), 1, 0, 0});
    rows.push_back('{make_item(ACT_NONE, 0, 5, 0, 0), 1, 0, 0});
    rows.push_back('{make_item(ACT_SNAP, 0, 32'h7fffffff, 0, 0), 1, 32'h7fffffff, 0});
    rows.push_back('{make_item(ACT_SNAP, 0, 32'h80000000, 0, 0), 1, 32'h80000000, 0});
    rows.push_back('{make_item(ACT_RETARGET, 0, 32'h00010000, 0, 0), 1, 32'h00010000, 0});
    for (int c = 0; c < 8; c++) begin
      rows.push_back('{make_item(ACT_RETARGET, 0, 32'h80000000 + c, 1000, c),
                       1, 32'h00010000 + ((c == 0) ? 0 : 0), 1});
      rows[rows.size()-1].fixed = (c == 0);
      rows.push_back('{make_item(ACT_ADVANCE, 333, 0, 0, 0), 0, 0, 0});
      rows.push_back('{make_item(ACT_ADVANCE, 24'hffffff, 0, 0, 0), 0, 0, 0});
      rows.push_back('{make_item(ACT_SNAP, 0, 32'h00010000, 0, 0), 0, 0, 0});
    end
    rows.push_back('{make_item(ACT_RETARGET, 0, 32'h7fffffff, 24'hffffff, CRV_OUT_BACK),
                     0, 0, 0});
    rows.push_back('{make_item(ACT_ADVANCE, 24'hfffffe, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_item(ACT_ADVANCE, 24'hffffff, 0, 0, 0), 0, 0, 0});
    foreach (rows[i]) begin
      row = rows[i];
      want = predict_tween(row.item);
      if (row.fixed) begin
        want.value  = row.value;
        want.moving = row.moving;
      end
      pending_results.push_back(want);
      send_item(row.item);
    end

    // Random phases over each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < 220; i++) apply_item(random_item());
      stop_sending();
      // Sender pauses until the block has drained
      while (pending_results.size() != 0) @(posedge clk);
    end

    // Long receiver hold-off while the sender keeps offering items
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++) apply_item(random_item());
        stop_sending();
      end
    join

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* eased_tween_animator.f */
hw/rtl/eta_pkg.sv
hw/rtl/eta_in_if.sv
hw/rtl/eta_out_if.sv
hw/rtl/eta_ctrl.sv
hw/rtl/eta_dp.sv
hw/rtl/eased_tween_animator.sv
tb/tb_eased_tween_animator.sv
